[hw/rtl/lcg48_pkg.sv]
`default_nettype none

package lcg48_pkg;

	localparam int MAX_BYTES_DEF = 64;

	localparam logic [23:0] LCG_MUL_LO = 24'hECE66D;
	localparam logic [23:0] LCG_MUL_HI = 24'h0005DE;
	localparam logic [47:0] LCG_ADD    = 48'hB;

	localparam logic [2:0] ACT_SEED = 3'd0;
	localparam logic [2:0] ACT_W32  = 3'd1;
	localparam logic [2:0] ACT_W64  = 3'd2;
	localparam logic [2:0] ACT_RUN  = 3'd3;
	localparam logic [2:0] ACT_UUID = 3'd4;

	localparam logic [6:0] UUID_BYTES = 7'd16;
	localparam logic [6:0] UUID_VER_REM = 7'd10;
	localparam logic [6:0] UUID_VAR_REM = 7'd8;

	typedef struct packed {
		logic [2:0]  op;
		logic [47:0] seed;
		logic [6:0]  count;
	} cmd_t;

	typedef struct packed {
		logic [63:0] value;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/lcg48_random_word_byte_uuid.sv]
// Flow: command queue, generator FSM (idle, multiply, add, emit), then result queue.
// A command is taken only while the FSM is idle; a seed load only sets the state. Each
// generator step is the split 24-bit multiply and add; word64 takes a second one, and a
// byte run or uuid one per four bytes, sent one per cycle unless the result queue is full.
// Reset: arst_n clears both queues and sets the generator state to zero.
`default_nettype none

module lcg48_random_word_byte_uuid #(
	parameter int MAX_BYTES = lcg48_pkg::MAX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  action,
	input  logic [47:0] seed_value,
	input  logic [6:0]  byte_count,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] value,
	output logic        last
);

	lcg48_pkg::cmd_t    cmd_in;
	lcg48_pkg::cmd_t    cmd_out;
	lcg48_pkg::result_t res_in;
	lcg48_pkg::result_t res_out;
	logic               keep;
	logic               cmd_empty;
	logic               cmd_pop;
	logic               res_full;
	logic               res_push;

	lcg48_front #(.MAX_BYTES(MAX_BYTES)) u_front (
		.action      (push),
		.action_code (action),
		.seed_value  (seed_value),
		.byte_count  (byte_count),
		.cmd         (cmd_in),
		.keep        (keep)
	);

	lcg48_fifo #(.W($bits(lcg48_pkg::cmd_t))) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (keep),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	lcg48_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	lcg48_fifo #(.W($bits(lcg48_pkg::result_t))) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign value = res_out.value;
	assign last  = res_out.last;

endmodule

`default_nettype wire

[hw/rtl/lcg48_fifo.sv]
`default_nettype none

module lcg48_fifo #(
	parameter int W = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lcg48_front.sv]
`default_nettype none

module lcg48_front #(
	parameter int MAX_BYTES = lcg48_pkg::MAX_BYTES_DEF
) (
	input  logic              action,
	input  logic [2:0]        action_code,
	input  logic [47:0]       seed_value,
	input  logic [6:0]        byte_count,
	output lcg48_pkg::cmd_t   cmd,
	output logic              keep
);

	logic [6:0] sat_count;

	assign sat_count = (byte_count > 7'(MAX_BYTES)) ? 7'(MAX_BYTES) : byte_count;

	always_comb begin
		cmd.op    = action_code;
		cmd.seed  = seed_value;
		cmd.count = sat_count;
		keep      = 1'b0;
		case (action_code)
			lcg48_pkg::ACT_SEED,
			lcg48_pkg::ACT_W32,
			lcg48_pkg::ACT_W64: begin
				keep = action;
			end
			lcg48_pkg::ACT_RUN: begin
				keep = action && (byte_count != 7'd0);
			end
			lcg48_pkg::ACT_UUID: begin
				cmd.count = lcg48_pkg::UUID_BYTES;
				keep      = action;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/lcg48_back.sv]
`default_nettype none

module lcg48_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  lcg48_pkg::cmd_t      cmd,
	output logic                 cmd_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output lcg48_pkg::result_t   res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]  st_q;
	logic [2:0]  op_q;
	logic [6:0]  rem_q;
	logic [2:0]  left_q;
	logic [1:0]  idx_q;
	logic        hi_done_q;
	logic [31:0] hi_q;
	logic [31:0] word_q;
	logic [47:0] lcg_q;
	logic [47:0] pp_ll_s1;
	logic [23:0] pp_hl_s1;
	logic [23:0] pp_lh_s1;
	logic [23:0] mid;
	logic [47:0] nxt;
	logic [7:0]  byte_raw;
	logic [7:0]  byte_fix;
	logic        is_word;

	assign mid     = pp_hl_s1 + pp_lh_s1;
	assign nxt     = pp_ll_s1 + {mid, 24'd0} + lcg48_pkg::LCG_ADD;
	assign is_word = (op_q == lcg48_pkg::ACT_W32) || (op_q == lcg48_pkg::ACT_W64);
	assign byte_raw = word_q[{idx_q, 3'b000} +: 8];

	assign cmd_pop  = (st_q == ST_IDLE) && cmd_valid;
	assign res_push = (st_q == ST_EMIT) && !res_full;

	always_comb begin
		byte_fix = byte_raw;
		if (op_q == lcg48_pkg::ACT_UUID) begin
			if (rem_q == lcg48_pkg::UUID_VER_REM) begin
				byte_fix = (byte_raw & 8'h0F) | 8'h40;
			end else if (rem_q == lcg48_pkg::UUID_VAR_REM) begin
				byte_fix = (byte_raw & 8'h3F) | 8'h80;
			end
		end
		if (op_q == lcg48_pkg::ACT_W64) begin
			res.value = {hi_q, word_q};
		end else if (op_q == lcg48_pkg::ACT_W32) begin
			res.value = {32'd0, word_q};
		end else begin
			res.value = {56'd0, byte_fix};
		end
		res.last = is_word || (rem_q == 7'd1);
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_MUL) begin
			pp_ll_s1 <= 48'(lcg_q[23:0]) * 48'(lcg48_pkg::LCG_MUL_LO);
			pp_hl_s1 <= 24'(lcg_q[47:24] * lcg48_pkg::LCG_MUL_LO);
			pp_lh_s1 <= 24'(lcg_q[23:0] * lcg48_pkg::LCG_MUL_HI);
		end
		if (st_q == ST_ADD) begin
			word_q <= nxt[47:16];
			if ((op_q == lcg48_pkg::ACT_W64) && !hi_done_q) begin
				hi_q <= nxt[47:16];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			op_q      <= lcg48_pkg::ACT_SEED;
			rem_q     <= 7'd0;
			left_q    <= 3'd0;
			idx_q     <= 2'd0;
			hi_done_q <= 1'b0;
			lcg_q     <= 48'd0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.op == lcg48_pkg::ACT_SEED) begin
							lcg_q <= cmd.seed;
						end else begin
							op_q      <= cmd.op;
							rem_q     <= cmd.count;
							hi_done_q <= 1'b0;
							st_q      <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					st_q <= ST_ADD;
				end
				ST_ADD: begin
					lcg_q <= nxt;
					if ((op_q == lcg48_pkg::ACT_W64) && !hi_done_q) begin
						hi_done_q <= 1'b1;
						st_q      <= ST_MUL;
					end else begin
						st_q <= ST_EMIT;
						if (rem_q >= 7'd4) begin
							idx_q  <= 2'd0;
							left_q <= 3'd4;
						end else begin
							idx_q  <= 2'd3 - rem_q[1:0];
							left_q <= {1'b0, rem_q[1:0]};
						end
					end
				end
				ST_EMIT: begin
					if (!res_full) begin
						if (is_word) begin
							st_q <= ST_IDLE;
						end else begin
							rem_q  <= rem_q - 7'd1;
							idx_q  <= idx_q + 2'd1;
							left_q <= left_q - 3'd1;
							if (rem_q == 7'd1) begin
								st_q <= ST_IDLE;
							end else if (left_q == 3'd1) begin
								st_q <= ST_MUL;
							end
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lcg48_chk.sv]
`default_nettype none

module lcg48_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        empty,
	input  logic        pop,
	input  logic [63:0] value,
	input  logic        last
);

	a_reset_clear: assert property (@(posedge clk) $rose(arst_n) |-> empty && !full)
		else $error("queues not clear after reset");

	a_byte_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last) |-> (value[63:8] == 56'd0))
		else $error("non-final result wider than a byte");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(value) && $stable(last)))
		else $error("waiting transaction changed");

	a_no_push_no_full: assert property (@(posedge clk) disable iff (!arst_n)
		(!full && !push) |=> !full)
		else $error("full rose without a push");

endmodule

bind lcg48_random_word_byte_uuid lcg48_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.value  (value),
	.last   (last)
);

`default_nettype wire
